// ----- design/aecp_pkg.sv -----
package aecp_pkg;

    // default grid and CSI limits
    localparam int unsigned DEF_TEXT_COLS     = 80;
    localparam int unsigned DEF_TEXT_ROWS     = 25;
    localparam int unsigned DEF_GRAPHIC_COLS  = 125;
    localparam int unsigned DEF_GRAPHIC_ROWS  = 60;
    localparam int unsigned DEF_CSI_MAX_CHARS = 31;
    localparam int unsigned DEF_MAX_PARAMS    = 4;

    // field widths
    localparam int ROW_W   = 6;
    localparam int COL_W   = 7;
    localparam int PARAM_W = 16;
    localparam int ATTR_W  = 8;
    localparam int RGB_W   = 24;

    // APB register map: one 32-bit register per word
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int REG_LSB = 2;
    localparam logic [APB_AW-REG_LSB-1:0] REG_GRAPHIC_MODE = 1'b0;

    localparam logic [PARAM_W-1:0] PARAM_MAX = '1;

    // color defaults and SGR codes
    localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h0F;
    localparam logic [ATTR_W-1:0] ATTR_BRIGHT = 8'h08;
    localparam logic [RGB_W-1:0]  RGB_RESET   = 24'hFFFFFF;

    localparam logic [PARAM_W-1:0] SGR_RESET     = 16'd0;
    localparam logic [PARAM_W-1:0] SGR_FG_LO     = 16'd30;
    localparam logic [PARAM_W-1:0] SGR_FG_HI     = 16'd37;
    localparam logic [PARAM_W-1:0] SGR_BRIGHT_LO = 16'd90;
    localparam logic [PARAM_W-1:0] SGR_BRIGHT_HI = 16'd97;

    localparam logic [2:0] VGA_OF_ANSI [8] = '{
        3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7
    };

    localparam logic [RGB_W-1:0] RGB_OF_ANSI [8] = '{
        24'h000000, 24'hFF5555, 24'h55FF55, 24'hFFFF55,
        24'h5555FF, 24'hFF55FF, 24'h55FFFF, 24'hFFFFFF
    };

    typedef enum logic [1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_ATTR  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    typedef struct packed {
        t_func       func;
        logic [7:0]  byte_value;
        logic [7:0]  attribute_value;
    } t_in_item;

    typedef struct packed {
        logic              cell_write;
        logic              cell_erase;
        logic [ROW_W-1:0]  cell_row;
        logic [COL_W-1:0]  cell_col;
        logic [7:0]        char_code;
        logic [ATTR_W-1:0] text_attr;
        logic [RGB_W-1:0]  rgb_color;
        logic              scroll_up;
        logic              clear_screen;
        logic              cursor_update;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
    } t_out_item;

    typedef struct packed {
        logic [ATTR_W-1:0] attr;
        logic [RGB_W-1:0]  rgb;
    } t_color;

    // one SGR parameter applied to the current colors
    function automatic t_color sgr_apply(logic [PARAM_W-1:0] v, t_color c);
        t_color             r;
        logic [PARAM_W-1:0] d30;
        logic [PARAM_W-1:0] d90;
        r   = c;
        d30 = v - SGR_FG_LO;
        d90 = v - SGR_BRIGHT_LO;
        if (v == SGR_RESET) begin
            r.attr = ATTR_RESET;
            r.rgb  = RGB_RESET;
        end else if (v >= SGR_FG_LO && v <= SGR_FG_HI) begin
            r.attr = (c.attr & ATTR_BRIGHT) | {5'b0, VGA_OF_ANSI[d30[2:0]]};
            r.rgb  = RGB_OF_ANSI[d30[2:0]];
        end else if (v >= SGR_BRIGHT_LO && v <= SGR_BRIGHT_HI) begin
            r.attr = ATTR_BRIGHT | {5'b0, VGA_OF_ANSI[d90[2:0]]};
            r.rgb  = RGB_OF_ANSI[d90[2:0]];
        end
        return r;
    endfunction

endpackage

// ----- design/aecp_apb.sv -----
module aecp_apb (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [aecp_pkg::APB_AW-1:0] paddr,
    input  logic [aecp_pkg::APB_DW-1:0] pwdata,
    output logic [aecp_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output logic                        o_graphic_mode
);
    import aecp_pkg::*;

    logic r_graphic_mode;
    logic wr_en;
    logic sel_mode;

    assign pready   = 1'b1;
    assign sel_mode = (paddr[APB_AW-1:REG_LSB] == REG_GRAPHIC_MODE);
    assign wr_en    = psel & penable & pwrite & pready & sel_mode;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_graphic_mode <= 1'b0;
        end else if (wr_en) begin
            r_graphic_mode <= pwdata[0];
        end
    end

    // read back
    assign prdata         = sel_mode ? {{(APB_DW-1){1'b0}}, r_graphic_mode} : '0;
    assign o_graphic_mode = r_graphic_mode;

endmodule

// ----- design/aecp_sgr.sv -----
module aecp_sgr #(
    parameter int unsigned MAX_PARAMS = aecp_pkg::DEF_MAX_PARAMS
) (
    input  logic [MAX_PARAMS-1:0][aecp_pkg::PARAM_W-1:0] i_params,
    input  logic [$clog2(MAX_PARAMS+1)-1:0]              i_param_index,
    input  aecp_pkg::t_color                             i_color,
    output aecp_pkg::t_color                             o_color
);
    import aecp_pkg::*;

    localparam int PIW = $clog2(MAX_PARAMS + 1);

    logic [PIW-1:0] last;
    t_color         acc;

    // apply parameters 0..last in order; 30-37 depends on the previous attr
    always_comb begin
        last = (i_param_index < PIW'(MAX_PARAMS)) ? i_param_index : PIW'(MAX_PARAMS - 1);
        acc  = i_color;
        for (int i = 0; i < MAX_PARAMS; i++) begin
            if (PIW'(i) <= last) begin
                acc = sgr_apply(i_params[i], acc);
            end
        end
        o_color = acc;
    end

endmodule

// ----- design/aecp_step.sv -----
module aecp_step #(
    parameter int unsigned TEXT_COLS     = aecp_pkg::DEF_TEXT_COLS,
    parameter int unsigned TEXT_ROWS     = aecp_pkg::DEF_TEXT_ROWS,
    parameter int unsigned GRAPHIC_COLS  = aecp_pkg::DEF_GRAPHIC_COLS,
    parameter int unsigned GRAPHIC_ROWS  = aecp_pkg::DEF_GRAPHIC_ROWS,
    parameter int unsigned CSI_MAX_CHARS = aecp_pkg::DEF_CSI_MAX_CHARS,
    parameter int unsigned MAX_PARAMS    = aecp_pkg::DEF_MAX_PARAMS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  aecp_pkg::t_in_item  i_item,
    input  logic                i_graphic_mode,
    output aecp_pkg::t_out_item o_result
);
    import aecp_pkg::*;

    localparam int PIW = $clog2(MAX_PARAMS + 1);
    localparam int CCW = $clog2(CSI_MAX_CHARS + 1);
    localparam int WW  = PARAM_W + 1;
    localparam int TAB_STOP = 8;

    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CMD_CUU   = 8'h41;
    localparam logic [7:0] CMD_CUD   = 8'h42;
    localparam logic [7:0] CMD_CUF   = 8'h43;
    localparam logic [7:0] CMD_CUB   = 8'h44;
    localparam logic [7:0] CMD_CUP   = 8'h48;
    localparam logic [7:0] CMD_ED    = 8'h4A;
    localparam logic [7:0] CMD_HVP   = 8'h66;
    localparam logic [7:0] CMD_SGR   = 8'h6D;
    localparam logic [PARAM_W-1:0] ED_ALL = 16'd2;

    typedef enum logic [2:0] {
        ST_NORMAL = 3'b001,
        ST_ESC    = 3'b010,
        ST_CSI    = 3'b100
    } t_parse_state;

    // digit accumulate, saturating
    function automatic logic [PARAM_W-1:0] acc_digit(logic [PARAM_W-1:0] p, logic [3:0] d);
        logic [PARAM_W+3:0] v;
        v = ({4'b0, p} << 3) + ({4'b0, p} << 1) + {{PARAM_W{1'b0}}, d};
        return (v > {4'b0, PARAM_MAX}) ? PARAM_MAX : v[PARAM_W-1:0];
    endfunction

    // parser and console state
    t_parse_state                     r_state, n_state;
    logic [ROW_W-1:0]                 r_row;
    logic [COL_W-1:0]                 r_col;
    t_color                           r_color, n_color, sgr_color;
    logic [MAX_PARAMS-1:0][PARAM_W-1:0] r_params, n_params;
    logic [PIW-1:0]                   r_pidx, n_pidx;
    logic [CCW-1:0]                   r_ccnt, n_ccnt;

    logic [WW-1:0]      cols, rows, x0, y0, x, y, nmove;
    logic [PARAM_W-1:0] p0, p1;
    logic [7:0]         b;
    logic [3:0]         digit;
    logic [7:0]         digit_full;
    logic               put, clear_p, collect, do_sgr;
    logic               wr, er, sc, cl, cu;
    logic [ROW_W-1:0]   wrow;
    logic [COL_W-1:0]   wcol;
    logic [7:0]         wch;

    assign b          = i_item.byte_value;
    assign digit_full = b - CH_0;
    assign digit      = digit_full[3:0];
    assign cols = i_graphic_mode ? WW'(GRAPHIC_COLS) : WW'(TEXT_COLS);
    assign rows = i_graphic_mode ? WW'(GRAPHIC_ROWS) : WW'(TEXT_ROWS);
    assign x0   = WW'(r_col);
    assign y0   = WW'(r_row);
    assign p0   = r_params[0];
    assign nmove = (p0 == '0) ? WW'(1) : WW'(p0);

    generate
        if (MAX_PARAMS > 1) begin : g_p1
            assign p1 = r_params[1];
        end else begin : g_no_p1
            assign p1 = '0;
        end
    endgenerate

    aecp_sgr #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_sgr (
        .i_params      (r_params),
        .i_param_index (r_pidx),
        .i_color       (r_color),
        .o_color       (sgr_color)
    );

    // byte decode, cursor moves, wrap and scroll
    always_comb begin
        n_state = r_state;
        x       = x0;
        y       = y0;
        put     = 1'b0;
        clear_p = 1'b0;
        collect = 1'b0;
        do_sgr  = 1'b0;
        wr      = 1'b0;
        er      = 1'b0;
        sc      = 1'b0;
        cl      = 1'b0;
        cu      = 1'b0;
        wrow    = '0;
        wcol    = '0;
        wch     = '0;
        n_color = r_color;
        unique case (i_item.func)
            FUNC_ATTR: begin
                n_color.attr = i_item.attribute_value;
            end
            FUNC_CLEAR: begin
                cl = 1'b1;
                x  = '0;
                y  = '0;
                cu = !i_graphic_mode;
            end
            FUNC_PUT: begin
                put = 1'b1;
                unique case (r_state)
                    ST_NORMAL: begin
                        if (b == CH_ESC) begin
                            n_state = ST_ESC;
                        end else if (b == CH_LF) begin
                            x = '0;
                            y = y0 + WW'(1);
                        end else if (b == CH_CR) begin
                            x = '0;
                        end else if (b == CH_TAB) begin
                            x = (x0 + WW'(TAB_STOP)) & ~WW'(TAB_STOP - 1);
                        end else if (b == CH_BS) begin
                            if (x0 != '0) begin
                                x = x0 - WW'(1);
                                if (i_graphic_mode) begin
                                    er   = 1'b1;
                                    wrow = r_row;
                                    wcol = r_col - COL_W'(1);
                                end
                            end
                        end else begin
                            wr   = 1'b1;
                            wrow = r_row;
                            wcol = r_col;
                            wch  = b;
                            x    = x0 + WW'(1);
                        end
                    end
                    ST_ESC: begin
                        if (b == CH_LBRACK) begin
                            n_state = ST_CSI;
                            clear_p = 1'b1;
                        end else begin
                            n_state = ST_NORMAL;
                        end
                    end
                    ST_CSI: begin
                        if ((b >= CH_0 && b <= CH_9) || b == CH_SEMI) begin
                            collect = 1'b1;
                        end else begin
                            n_state = ST_NORMAL;
                            case (b) inside
                                CMD_SGR: do_sgr = 1'b1;
                                CMD_CUU: y = (y0 > nmove) ? y0 - nmove : '0;
                                CMD_CUD: y = (y0 + nmove < rows) ? y0 + nmove : rows - WW'(1);
                                CMD_CUF: x = (x0 + nmove < cols) ? x0 + nmove : cols - WW'(1);
                                CMD_CUB: x = (x0 > nmove) ? x0 - nmove : '0;
                                CMD_CUP, CMD_HVP: begin
                                    if (r_pidx != '0) begin
                                        y = (p0 != '0) ? WW'(p0) - WW'(1) : '0;
                                        x = (p1 != '0) ? WW'(p1) - WW'(1) : '0;
                                    end else begin
                                        x = '0;
                                        y = '0;
                                    end
                                end
                                CMD_ED: begin
                                    if (p0 == ED_ALL) begin
                                        cl = 1'b1;
                                        x  = '0;
                                        y  = '0;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    default: n_state = ST_NORMAL;
                endcase
            end
            default: ;
        endcase

        if (do_sgr) begin
            n_color = sgr_color;
        end

        // wrap past the right edge, scroll past the bottom
        if (put) begin
            if (x >= cols) begin
                x = '0;
                y = y + WW'(1);
            end
            if (y >= rows) begin
                sc = 1'b1;
                y  = rows - WW'(1);
            end
            cu = (n_state == ST_NORMAL) && !i_graphic_mode;
        end
    end

    // CSI parameter collection
    always_comb begin
        n_params = r_params;
        n_pidx   = r_pidx;
        n_ccnt   = r_ccnt;
        if (clear_p) begin
            n_params = '0;
            n_pidx   = '0;
            n_ccnt   = '0;
        end else if (collect && r_ccnt < CCW'(CSI_MAX_CHARS)) begin
            n_ccnt = r_ccnt + CCW'(1);
            if (r_pidx < PIW'(MAX_PARAMS)) begin
                if (b == CH_SEMI) begin
                    n_pidx = r_pidx + PIW'(1);
                end else begin
                    for (int i = 0; i < MAX_PARAMS; i++) begin
                        if (r_pidx == PIW'(i)) begin
                            n_params[i] = acc_digit(r_params[i], digit);
                        end
                    end
                end
            end
        end
    end

    // state update per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_NORMAL;
            r_row    <= '0;
            r_col    <= '0;
            r_color  <= '{attr: ATTR_RESET, rgb: RGB_RESET};
            r_params <= '0;
            r_pidx   <= '0;
            r_ccnt   <= '0;
        end else if (i_fire) begin
            r_state  <= n_state;
            r_row    <= y[ROW_W-1:0];
            r_col    <= x[COL_W-1:0];
            r_color  <= n_color;
            r_params <= n_params;
            r_pidx   <= n_pidx;
            r_ccnt   <= n_ccnt;
        end
    end

    // result of this beat
    always_comb begin
        o_result.cell_write    = wr;
        o_result.cell_erase    = er;
        o_result.cell_row      = wrow;
        o_result.cell_col      = wcol;
        o_result.char_code     = wch;
        o_result.text_attr     = n_color.attr;
        o_result.rgb_color     = n_color.rgb;
        o_result.scroll_up     = sc;
        o_result.clear_screen  = cl;
        o_result.cursor_update = cu;
        o_result.cursor_row    = y[ROW_W-1:0];
        o_result.cursor_col    = x[COL_W-1:0];
    end

endmodule

// ----- design/ansi_escape_console_parser_unit.sv -----
// Flow: an accepted beat waits in the input register until the result register
// is free or being taken, then moves there and is offered as its result beat.
// Throughput: one beat per cycle unless the result side stalls; the input and
// result registers form a two-stage pipeline, and the parser state updates in a
// single pass. Reset: synchronous, active low; clears parser, cursor, colors, CSI
// params, the mode register and the valid flags of both pipeline stages.
module ansi_escape_console_parser_unit #(
    parameter int unsigned TEXT_COLS     = aecp_pkg::DEF_TEXT_COLS,
    parameter int unsigned TEXT_ROWS     = aecp_pkg::DEF_TEXT_ROWS,
    parameter int unsigned GRAPHIC_COLS  = aecp_pkg::DEF_GRAPHIC_COLS,
    parameter int unsigned GRAPHIC_ROWS  = aecp_pkg::DEF_GRAPHIC_ROWS,
    parameter int unsigned CSI_MAX_CHARS = aecp_pkg::DEF_CSI_MAX_CHARS,
    parameter int unsigned MAX_PARAMS    = aecp_pkg::DEF_MAX_PARAMS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  aecp_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output aecp_pkg::t_out_item         o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [aecp_pkg::APB_AW-1:0] paddr,
    input  logic [aecp_pkg::APB_DW-1:0] pwdata,
    output logic [aecp_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import aecp_pkg::*;

    logic      r_in_vld;
    t_in_item  r_in_item;
    logic      r_out_vld;
    t_out_item r_out_item;
    t_out_item n_out_item;
    logic      advance;
    logic      graphic_mode;

    aecp_apb u_apb (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_graphic_mode (graphic_mode)
    );

    // item moves to the result register when that register is free or being taken
    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    aecp_step #(
        .TEXT_COLS     (TEXT_COLS),
        .TEXT_ROWS     (TEXT_ROWS),
        .GRAPHIC_COLS  (GRAPHIC_COLS),
        .GRAPHIC_ROWS  (GRAPHIC_ROWS),
        .CSI_MAX_CHARS (CSI_MAX_CHARS),
        .MAX_PARAMS    (MAX_PARAMS)
    ) u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (advance),
        .i_item         (r_in_item),
        .i_graphic_mode (graphic_mode),
        .o_result       (n_out_item)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_item;

endmodule

// ----- design/aecp_checker.sv -----
module aecp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input aecp_pkg::t_out_item o_out_data
);
    import aecp_pkg::*;

    // a clear never comes with a write, erase or scroll
    a_clear_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.clear_screen |->
            !o_out_data.cell_write && !o_out_data.cell_erase && !o_out_data.scroll_up)
        else $error("clear beat also writes, erases or scrolls");

    // a clear homes the cursor
    a_clear_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.clear_screen |->
            o_out_data.cursor_row == '0 && o_out_data.cursor_col == '0)
        else $error("clear beat leaves cursor away from home");

    // erase is graphic only: no text cursor, no written char
    a_erase_graphic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.cell_erase |->
            !o_out_data.cursor_update && !o_out_data.cell_write &&
            o_out_data.char_code == '0)
        else $error("erase beat carries text cursor or char");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed under stall");

endmodule

bind ansi_escape_console_parser_unit aecp_checker u_aecp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ----- verif/testbench.sv -----
module testbench;
    import aecp_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PHASE_ITEMS    = 100;
    localparam int unsigned NUM_PHASES     = 5;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned DRAIN_CYCLES   = 8;

    localparam logic [APB_AW-1:0] MODE_ADDR = {REG_GRAPHIC_MODE, {REG_LSB{1'b0}}};

    // terminal bytes with special meaning
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBRK  = "[";
    localparam logic [7:0] CH_SEMI  = ";";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";

    // CSI final bytes
    localparam logic [7:0] CSI_SGR     = "m";
    localparam logic [7:0] CSI_UP      = "A";
    localparam logic [7:0] CSI_DOWN    = "B";
    localparam logic [7:0] CSI_FWD     = "C";
    localparam logic [7:0] CSI_BACK    = "D";
    localparam logic [7:0] CSI_POS     = "H";
    localparam logic [7:0] CSI_POS_ALT = "f";
    localparam logic [7:0] CSI_ERASE   = "J";

    localparam logic [7:0] FINAL_CODES [10] = '{
        CSI_SGR, CSI_SGR, CSI_SGR, CSI_UP, CSI_DOWN,
        CSI_FWD, CSI_BACK, CSI_POS, CSI_POS_ALT, CSI_ERASE
    };

    localparam logic [7:0] FG_VGA_CODE [8] = '{
        8'd0, 8'd4, 8'd2, 8'd6, 8'd1, 8'd5, 8'd3, 8'd7
    };
    localparam logic [23:0] FG_RGB_CODE [8] = '{
        24'h000000, 24'hFF5555, 24'h55FF55, 24'hFFFF55,
        24'h5555FF, 24'hFF55FF, 24'h55FFFF, 24'hFFFFFF
    };

    typedef enum logic [1:0] {
        PS_NORMAL = 2'd0,
        PS_ESC    = 2'd1,
        PS_CSI    = 2'd2
    } t_parse_phase;

    typedef struct packed {
        t_in_item  beat;
        logic      typed;
        t_out_item want;
    } t_directed_row;

    // DUT signals
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_data;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [APB_AW-1:0]    paddr       = '0;
    logic [APB_DW-1:0]    pwdata      = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // predicted console state
    logic                 mode_q   = 1'b0;
    t_parse_phase         ps_q     = PS_NORMAL;
    int unsigned          cur_x    = 0;
    int unsigned          cur_y    = 0;
    logic [7:0]           attr_q   = 8'h0F;
    logic [23:0]          rgb_q    = 24'hFFFFFF;
    int unsigned          csi_arg [4] = '{0, 0, 0, 0};
    int unsigned          arg_idx  = 0;
    int unsigned          csi_len  = 0;

    t_out_item            predicted_reports [$];
    t_in_item             pending_beats [$];
    int unsigned          mismatches   = 0;
    int unsigned          reports_seen = 0;
    int unsigned          stall_cycles = 0;
    bit                   in_idle_en   = 1'b1;
    bit                   out_idle_en  = 1'b1;

    // directed stimulus: extremes, controls, escape handling, saturating cursor position
    t_directed_row directed_rows [24] = '{
        '{'{FUNC_NOP,   8'hFF, 8'hFF}, 1'b1, '{1'b0, 1'b0, 6'd0, 7'd0, 8'h00, 8'h0F,
            24'hFFFFFF, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0}},
        '{'{FUNC_PUT,   8'h41, 8'h00}, 1'b1, '{1'b1, 1'b0, 6'd0, 7'd0, 8'h41, 8'h0F,
            24'hFFFFFF, 1'b0, 1'b0, 1'b1, 6'd0, 7'd1}},
        '{'{FUNC_ATTR,  8'h00, 8'hFF}, 1'b1, '{1'b0, 1'b0, 6'd0, 7'd0, 8'h00, 8'hFF,
            24'hFFFFFF, 1'b0, 1'b0, 1'b0, 6'd0, 7'd1}},
        '{'{FUNC_PUT,   8'hFF, 8'h00}, 1'b1, '{1'b1, 1'b0, 6'd0, 7'd1, 8'hFF, 8'hFF,
            24'hFFFFFF, 1'b0, 1'b0, 1'b1, 6'd0, 7'd2}},
        '{'{FUNC_PUT,   8'h00, 8'hFF}, 1'b0, '0},
        '{'{FUNC_PUT,   CH_TAB, 8'h5A}, 1'b0, '0},
        '{'{FUNC_PUT,   CH_BS,  8'hA5}, 1'b0, '0},
        '{'{FUNC_PUT,   CH_CR,  8'h00}, 1'b0, '0},
        '{'{FUNC_PUT,   CH_LF,  8'h00}, 1'b0, '0},
        '{'{FUNC_PUT,   CH_ESC, 8'h00}, 1'b0, '0},
        '{'{FUNC_PUT,   8'h78,  8'h00}, 1'b0, '0},
        '{'{FUNC_PUT,   CH_ESC, 8'h00}, 1'b0, '0},
        '{'{FUNC_PUT,   CH_LBRK, 8'h00}, 1'b0, '0},
        '{'{FUNC_PUT,   CH_NINE, 8'h00}, 1'b0, '0},
        '{'{FUNC_PUT,   CH_NINE, 8'h00}, 1'b0, '0},
        '{'{FUNC_PUT,   CH_NINE, 8'h00}, 1'b0, '0},
        '{'{FUNC_PUT,   CH_NINE, 8'h00}, 1'b0, '0},
        '{'{FUNC_PUT,   CH_NINE, 8'h00}, 1'b0, '0},
        '{'{FUNC_PUT,   CH_SEMI, 8'h00}, 1'b0, '0},
        '{'{FUNC_PUT,   8'h33,  8'h00}, 1'b0, '0},
        '{'{FUNC_PUT,   8'h34,  8'h00}, 1'b0, '0},
        '{'{FUNC_PUT,   CSI_POS, 8'h00}, 1'b0, '0},
        '{'{FUNC_ATTR,  8'hFF,  8'h00}, 1'b0, '0},
        '{'{FUNC_CLEAR, 8'hFF,  8'hFF}, 1'b1, '{1'b0, 1'b0, 6'd0, 7'd0, 8'h00, 8'h00,
            24'hFFFFFF, 1'b0, 1'b1, 1'b1, 6'd0, 7'd0}}
    };

    ansi_escape_console_parser_unit u_top (
        .i_clk, .i_rst_n,
        .i_in_valid, .o_in_ready, .i_in_data,
        .o_out_valid, .i_out_ready, .o_out_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always #5 i_clk = ~i_clk;

    // console predictor: one report per accepted beat
    function automatic t_out_item console_step(input t_in_item it);
        t_out_item   r;
        int unsigned cols;
        int unsigned rows;
        int unsigned x;
        int unsigned y;
        int unsigned n;
        int unsigned last;
        int unsigned v;
        int unsigned k;
        logic [7:0]  b;
        r    = '0;
        b    = it.byte_value;
        cols = mode_q ? DEF_GRAPHIC_COLS : DEF_TEXT_COLS;
        rows = mode_q ? DEF_GRAPHIC_ROWS : DEF_TEXT_ROWS;
        x    = cur_x;
        y    = cur_y;
        case (it.func)
            FUNC_ATTR: begin
                attr_q = it.attribute_value;
            end
            FUNC_CLEAR: begin
                r.clear_screen  = 1'b1;
                x               = 0;
                y               = 0;
                r.cursor_update = !mode_q;
            end
            FUNC_PUT: begin
                case (ps_q)
                    PS_NORMAL: begin
                        if (b == CH_ESC) begin
                            ps_q = PS_ESC;
                        end else if (b == CH_LF) begin
                            x = 0;
                            y = y + 1;
                        end else if (b == CH_CR) begin
                            x = 0;
                        end else if (b == CH_TAB) begin
                            x = (x + 8) & ~32'd7;
                        end else if (b == CH_BS) begin
                            if (x > 0) begin
                                x = x - 1;
                                // graphic grid blanks the cell it backs over
                                if (mode_q) begin
                                    r.cell_erase = 1'b1;
                                    r.cell_row   = y[5:0];
                                    r.cell_col   = x[6:0];
                                end
                            end
                        end else begin
                            r.cell_write = 1'b1;
                            r.cell_row   = y[5:0];
                            r.cell_col   = x[6:0];
                            r.char_code  = b;
                            x            = x + 1;
                        end
                    end
                    PS_ESC: begin
                        if (b == CH_LBRK) begin
                            ps_q    = PS_CSI;
                            csi_arg = '{0, 0, 0, 0};
                            arg_idx = 0;
                            csi_len = 0;
                        end else begin
                            ps_q = PS_NORMAL;
                        end
                    end
                    default: begin
                        if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI) begin
                            // parameter collection, capped in length and slot count
                            if (csi_len < DEF_CSI_MAX_CHARS) begin
                                csi_len = csi_len + 1;
                                if (arg_idx < DEF_MAX_PARAMS) begin
                                    if (b == CH_SEMI) begin
                                        arg_idx = arg_idx + 1;
                                    end else begin
                                        v = csi_arg[arg_idx] * 10 + (b - CH_ZERO);
                                        csi_arg[arg_idx] = (v > 65535) ? 65535 : v;
                                    end
                                end
                            end
                        end else begin
                            n = (csi_arg[0] != 0) ? csi_arg[0] : 1;
                            case (b)
                                CSI_SGR: begin
                                    last = (arg_idx < DEF_MAX_PARAMS) ? arg_idx
                                                                      : DEF_MAX_PARAMS - 1;
                                    for (k = 0; k <= last; k++) begin
                                        v = csi_arg[k];
                                        if (v == 0) begin
                                            attr_q = 8'h0F;
                                            rgb_q  = 24'hFFFFFF;
                                        end else if (v >= 30 && v <= 37) begin
                                            attr_q = (attr_q & 8'h08) | FG_VGA_CODE[v - 30];
                                            rgb_q  = FG_RGB_CODE[v - 30];
                                        end else if (v >= 90 && v <= 97) begin
                                            attr_q = 8'h08 | FG_VGA_CODE[v - 90];
                                            rgb_q  = FG_RGB_CODE[v - 90];
                                        end
                                    end
                                end
                                CSI_UP:   y = (y > n) ? y - n : 0;
                                CSI_DOWN: y = (y + n < rows) ? y + n : rows - 1;
                                CSI_FWD:  x = (x + n < cols) ? x + n : cols - 1;
                                CSI_BACK: x = (x > n) ? x - n : 0;
                                CSI_POS, CSI_POS_ALT: begin
                                    // no clamp here; wrap and scroll below fix it up
                                    if (arg_idx >= 1) begin
                                        y = (csi_arg[0] > 0) ? csi_arg[0] - 1 : 0;
                                        x = (csi_arg[1] > 0) ? csi_arg[1] - 1 : 0;
                                    end else begin
                                        x = 0;
                                        y = 0;
                                    end
                                end
                                CSI_ERASE: begin
                                    if (csi_arg[0] == 2) begin
                                        r.clear_screen = 1'b1;
                                        x              = 0;
                                        y              = 0;
                                    end
                                end
                                default: ;
                            endcase
                            ps_q = PS_NORMAL;
                        end
                    end
                endcase
                // line wrap, then scroll
                if (x >= cols) begin
                    x = 0;
                    y = y + 1;
                end
                if (y >= rows) begin
                    r.scroll_up = 1'b1;
                    y           = rows - 1;
                end
                r.cursor_update = (ps_q == PS_NORMAL) && !mode_q;
            end
            default: ;
        endcase
        cur_x          = x % 128;
        cur_y          = y % 64;
        r.text_attr    = attr_q;
        r.rgb_color    = rgb_q;
        r.cursor_row   = cur_y[5:0];
        r.cursor_col   = cur_x[6:0];
        return r;
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("report %0d: %s expected 0x%0h, got 0x%0h",
                         reports_seen, name, want, got);
        end
    endfunction

    function automatic void check_console_report(input t_out_item got);
        t_out_item want;
        reports_seen++;
        if (predicted_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("report %0d: unexpected beat 0x%h", reports_seen, got);
            return;
        end
        want = predicted_reports.pop_front();
        compare_field("cell_write",    want.cell_write,    got.cell_write);
        compare_field("cell_erase",    want.cell_erase,    got.cell_erase);
        compare_field("cell_row",      want.cell_row,      got.cell_row);
        compare_field("cell_col",      want.cell_col,      got.cell_col);
        compare_field("char_code",     want.char_code,     got.char_code);
        compare_field("text_attr",     want.text_attr,     got.text_attr);
        compare_field("rgb_color",     want.rgb_color,     got.rgb_color);
        compare_field("scroll_up",     want.scroll_up,     got.scroll_up);
        compare_field("clear_screen",  want.clear_screen,  got.clear_screen);
        compare_field("cursor_update", want.cursor_update, got.cursor_update);
        compare_field("cursor_row",    want.cursor_row,    got.cursor_row);
        compare_field("cursor_col",    want.cursor_col,    got.cursor_col);
    endfunction

    function automatic void push_put(input logic [7:0] b);
        pending_beats.push_back('{FUNC_PUT, b, 8'($urandom)});
    endfunction

    // one random chunk of console traffic: bytes, controls, escape sequences or other beats
    function automatic void queue_console_chunk();
        int unsigned kind;
        int unsigned nargs;
        int unsigned sel;
        int unsigned v;
        int unsigned k;
        int unsigned i;
        logic [7:0]  b;
        string       digits;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            push_put($urandom_range(0, 1) ? 8'($urandom_range(32, 126)) : 8'($urandom));
        end else if (kind < 45) begin
            case ($urandom_range(0, 4))
                0: push_put(CH_LF);
                1: push_put(CH_CR);
                2: push_put(CH_TAB);
                3: push_put(CH_BS);
                default: push_put(8'($urandom_range(0, 31)));
            endcase
        end else if (kind < 80) begin
            push_put(CH_ESC);
            push_put(CH_LBRK);
            if (kind < 75) begin
                nargs = $urandom_range(0, 5);
                for (k = 0; k < nargs; k++) begin
                    if (k > 0)
                        push_put(CH_SEMI);
                    sel = $urandom_range(0, 9);
                    case (sel)
                        0:       v = 0;
                        1, 2, 3: v = 30 + $urandom_range(0, 7);
                        4, 5:    v = 90 + $urandom_range(0, 7);
                        6:       v = $urandom_range(1, 3);
                        7:       v = $urandom_range(0, 200);
                        default: v = $urandom_range(60000, 99999);
                    endcase
                    // an empty parameter reads as zero
                    if (sel != 9) begin
                        digits = $sformatf("%0d", v);
                        for (i = 0; i < digits.len(); i++)
                            push_put(digits[i]);
                    end
                end
            end else begin
                // overlong sequence that can run past the character cap
                nargs = $urandom_range(28, 45);
                for (k = 0; k < nargs; k++)
                    push_put($urandom_range(0, 3) == 0 ? CH_SEMI
                                                       : 8'(CH_ZERO + $urandom_range(0, 9)));
            end
            if ($urandom_range(0, 9) == 0) begin
                do b = 8'($urandom);
                while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI);
                push_put(b);
            end else begin
                push_put(FINAL_CODES[$urandom_range(0, 9)]);
            end
        end else if (kind < 85) begin
            push_put(CH_ESC);
            push_put(8'($urandom));
        end else if (kind < 93) begin
            pending_beats.push_back('{FUNC_ATTR, 8'($urandom), 8'($urandom)});
        end else if (kind < 97) begin
            pending_beats.push_back('{FUNC_CLEAR, 8'($urandom), 8'($urandom)});
        end else begin
            pending_beats.push_back('{FUNC_NOP, 8'($urandom), 8'($urandom)});
        end
    endfunction

    // present one beat, hold it until accepted, then record its report
    task automatic send_item(input t_in_item it, input logic typed, input t_out_item want);
        int unsigned gap;
        t_out_item   predicted;
        gap = in_idle_en ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = console_step(it);
        predicted_reports.push_back(typed ? want : predicted);
    endtask

    // drop valid and wait for every outstanding report
    task automatic settle_results(input int unsigned extra);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (predicted_reports.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    // APB write of the mode register, followed by a read-back
    task automatic write_graphic_mode(input logic m);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODE_ADDR;
        pwdata  <= {{(APB_DW-1){1'b0}}, m};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        compare_field("graphic_mode read-back", {{(APB_DW-1){1'b0}}, m}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        mode_q   = m;
    endtask

    // result side: random stalls, check each beat as it is taken
    initial begin
        int unsigned gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = out_idle_en ? $urandom_range(0, 16) : 0;
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            check_console_report(o_out_data);
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("[ansi_escape_console_parser_unit] ERROR");
                $finish;
            end
        end
    end

    // main sequence
    initial begin
        int unsigned phase;
        int unsigned phase_items;
        bit          drained;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_graphic_mode(1'b0);

        foreach (directed_rows[k])
            send_item(directed_rows[k].beat, directed_rows[k].typed, directed_rows[k].want);

        // random phases alternate grids and idle patterns
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            settle_results(SETTLE_CYCLES);
            write_graphic_mode(phase % 2 == 0);
            case (phase % 4)
                0: begin in_idle_en = 1'b1; out_idle_en = 1'b1; end
                1: begin in_idle_en = 1'b0; out_idle_en = 1'b0; end
                2: begin in_idle_en = 1'b1; out_idle_en = 1'b0; end
                default: begin in_idle_en = 1'b0; out_idle_en = 1'b1; end
            endcase
            if (phase == NUM_PHASES - 1) begin
                in_idle_en  = $urandom_range(0, 1);
                out_idle_en = $urandom_range(0, 1);
            end
            phase_items = 0;
            drained     = 1'b0;
            while (phase_items < PHASE_ITEMS) begin
                queue_console_chunk();
                while (pending_beats.size() != 0) begin
                    send_item(pending_beats.pop_front(), 1'b0, '0);
                    phase_items++;
                end
                // mid-phase pause until the pipeline is empty
                if (!drained && phase_items >= PHASE_ITEMS / 2) begin
                    settle_results(0);
                    drained = 1'b1;
                end
            end
        end

        settle_results(DRAIN_CYCLES);
        if (mismatches == 0)
            $display("[ansi_escape_console_parser_unit] OK");
        else
            $display("[ansi_escape_console_parser_unit] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
design/aecp_pkg.sv
design/aecp_apb.sv
design/aecp_sgr.sv
design/aecp_step.sv
design/ansi_escape_console_parser_unit.sv
design/aecp_checker.sv
verif/testbench.sv
